FILE: hw/rtl/assert_macros.svh
// Assertion macros for the image rotation RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on i_clk, disabled during reset.
`define IRN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled during reset.
`define IRN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/irn_pkg.sv
// Types, constants and helpers shared by the image rotation block.
`default_nettype none

package irn_pkg;

    // Field and register widths
    localparam int WW         = 9;
    localparam int SIZE_MAX   = (1 << WW) - 1;
    localparam int FS_W       = 2 * WW;
    localparam int TRIG_W     = 16;
    localparam int FRAC_BITS  = 14;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Rotation datapath widths: offset from center, product, floored part, source coord
    localparam int DX_W   = 11;
    localparam int DU_W   = DX_W - 1;
    localparam int PROD_W = DX_W + TRIG_W;
    localparam int PART_W = PROD_W - FRAC_BITS;
    localparam int SRC_W  = PART_W + 2;

    // Reset values of the configuration registers
    localparam logic [WW-1:0]     RESET_SIZE = WW'(256);
    localparam logic [TRIG_W-1:0] RESET_SIN  = TRIG_W'(0);
    localparam logic [TRIG_W-1:0] RESET_COS  = TRIG_W'(16384);

    // Request function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_PRODUCE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SIN    = 2'd2,
        REG_COS    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic            func;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            last_pixel;
    } t_out_item;

    // Active configuration, sizes already clamped
    typedef struct packed {
        logic [WW-1:0]     width;
        logic [WW-1:0]     height;
        logic [TRIG_W-1:0] sin_v;
        logic [TRIG_W-1:0] cos_v;
    } t_cfg;

    // Per-stage control carried down the pipeline
    typedef struct packed {
        logic valid;
        logic load;
        logic last;
    } t_ctl;

    // Clamp a size register to 1..lim
    function automatic logic [WW-1:0] clamp_size(input logic [WW-1:0] v,
                                                 input logic [WW-1:0] lim);
        logic [WW-1:0] res;
        if (v == '0) begin
            res = WW'(1);
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/irn_stream_if.sv
// Valid/ready stream interface carrying one request or result payload.
`default_nettype none

interface irn_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/image_rotate_nearest_core.sv
// Top level of the nearest-neighbor image rotation block.
//
//  channel   dir  payload                                  accepted when
//  i_req     in   func, red_in, green_in, blue_in          valid && ready
//  o_rsp     out  red_out, green_out, blue_out, last_pixel valid && ready
//  i_cfg_*   in   register index, write data               i_cfg_we
//
// One request per clock while no result is stalled; a produce result is presented
// through the input, product, address and store-read registers.
// The frame store has a single port, one load write or one produce read per slot.
// Reset clears counters and pipeline valids and loads the config reset values; the store has no clearing pass.
// An unread result freezes the whole pipeline and drops i_req.ready.
`default_nettype none

module image_rotate_nearest_core import irn_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    irn_stream_if.sink            i_req,
    irn_stream_if.source          o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int W_LIM  = (MAX_WIDTH > SIZE_MAX) ? SIZE_MAX : MAX_WIDTH;
    localparam int H_LIM  = (MAX_HEIGHT > SIZE_MAX) ? SIZE_MAX : MAX_HEIGHT;
    localparam int COL_W  = $clog2(W_LIM);
    localparam int ROW_W  = $clog2(H_LIM);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cfg              cfg;
    logic              adv;

    t_ctl              scan_ctl;
    t_pixel            scan_pix;
    logic [ADDR_W-1:0] scan_addr;
    logic [COL_W-1:0]  scan_col;
    logic [ROW_W-1:0]  scan_row;

    t_ctl              rot_ctl;
    t_pixel            rot_pix;
    logic [ADDR_W-1:0] rot_addr;
    logic              rot_in_frame;

    logic              out_valid;
    t_out_item         out_item;

    // Move the pipeline whenever the result register is free or being taken
    assign adv         = !out_valid || o_rsp.ready;
    assign i_req.ready = adv;

    irn_config #(
        .WIDTH_LIMIT  (W_LIM),
        .HEIGHT_LIMIT (H_LIM)
    ) u_config (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    irn_scan #(
        .ADDR_W (ADDR_W),
        .COL_W  (COL_W),
        .ROW_W  (ROW_W)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_req.valid),
        .i_item  (i_req.payload),
        .i_cfg   (cfg),
        .o_ctl   (scan_ctl),
        .o_pix   (scan_pix),
        .o_addr  (scan_addr),
        .o_col   (scan_col),
        .o_row   (scan_row)
    );

    irn_rotate #(
        .ADDR_W (ADDR_W),
        .COL_W  (COL_W),
        .ROW_W  (ROW_W)
    ) u_rotate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_ctl      (scan_ctl),
        .i_pix      (scan_pix),
        .i_addr     (scan_addr),
        .i_col      (scan_col),
        .i_row      (scan_row),
        .i_cfg      (cfg),
        .o_ctl      (rot_ctl),
        .o_pix      (rot_pix),
        .o_addr     (rot_addr),
        .o_in_frame (rot_in_frame)
    );

    irn_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_ctl      (rot_ctl),
        .i_pix      (rot_pix),
        .i_addr     (rot_addr),
        .i_in_frame (rot_in_frame),
        .o_valid    (out_valid),
        .o_item     (out_item)
    );

    assign o_rsp.valid   = out_valid;
    assign o_rsp.payload = out_item;

    // A stalled result must block new requests
    `IRN_ASSERT_NOW(a_stall_blocks_req, o_rsp.valid && !o_rsp.ready, !i_req.ready,
        "request taken while a result is stalled")
    // A result only comes from a produce request in the store-access slot
    `IRN_ASSERT_NOW(a_result_from_produce, $rose(o_rsp.valid),
        $past(rot_ctl.valid && !rot_ctl.load), "result without a produce request")
    // A frozen pipeline keeps the store address and slot control
    `IRN_ASSERT_NEXT(a_freeze_holds_slot, !adv, $stable(rot_addr) && $stable(rot_ctl),
        "store slot changed during a stall")

endmodule

`default_nettype wire

FILE: hw/rtl/irn_config.sv
// Configuration registers of the image rotation block with size clamping.
`default_nettype none

module irn_config import irn_pkg::*; #(
    parameter int WIDTH_LIMIT  = 256,
    parameter int HEIGHT_LIMIT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    localparam logic [WW-1:0] W_LIMIT = WW'(WIDTH_LIMIT);
    localparam logic [WW-1:0] H_LIMIT = WW'(HEIGHT_LIMIT);

    t_cfg r_cfg;

    // Write one register; sizes are clamped on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= clamp_size(RESET_SIZE, W_LIMIT);
            r_cfg.height <= clamp_size(RESET_SIZE, H_LIMIT);
            r_cfg.sin_v  <= RESET_SIN;
            r_cfg.cos_v  <= RESET_COS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_WIDTH:  r_cfg.width  <= clamp_size(i_cfg_data[WW-1:0], W_LIMIT);
                REG_HEIGHT: r_cfg.height <= clamp_size(i_cfg_data[WW-1:0], H_LIMIT);
                REG_SIN:    r_cfg.sin_v  <= i_cfg_data[TRIG_W-1:0];
                REG_COS:    r_cfg.cos_v  <= i_cfg_data[TRIG_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hw/rtl/irn_scan.sv
// Raster counters for loading and producing, and the input register stage.
`default_nettype none

module irn_scan import irn_pkg::*; #(
    parameter int ADDR_W = 16,
    parameter int COL_W  = 8,
    parameter int ROW_W  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  t_in_item          i_item,
    input  t_cfg              i_cfg,
    output t_ctl              o_ctl,
    output t_pixel            o_pix,
    output logic [ADDR_W-1:0] o_addr,
    output logic [COL_W-1:0]  o_col,
    output logic [ROW_W-1:0]  o_row
);

    logic [ADDR_W-1:0] r_load_idx, n_load_idx;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    t_ctl              r_s1_ctl;
    t_pixel            r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;

    logic [FS_W-1:0]   frame_size;
    logic [ADDR_W-1:0] load_last;
    logic              take;
    logic              is_load;
    logic              col_end;
    logic              row_end;

    assign take       = i_adv && i_valid;
    assign is_load    = (i_item.func == FUNC_LOAD);
    assign frame_size = FS_W'(i_cfg.width) * FS_W'(i_cfg.height);
    assign load_last  = ADDR_W'(frame_size - FS_W'(1));
    assign col_end    = (WW'(r_col) >= (i_cfg.width - WW'(1)));
    assign row_end    = (WW'(r_row) >= (i_cfg.height - WW'(1)));

    // Advance the load index or the output raster position
    always_comb begin
        n_load_idx = r_load_idx;
        n_col      = r_col;
        n_row      = r_row;
        if (take) begin
            if (is_load) begin
                n_load_idx = (r_load_idx >= load_last) ? '0 : r_load_idx + ADDR_W'(1);
            end else if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_load_idx <= n_load_idx;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    // Capture the request control; an empty slot enters as a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (i_adv) begin
            r_s1_ctl.valid <= i_valid;
            r_s1_ctl.load  <= is_load;
            r_s1_ctl.last  <= col_end && row_end;
        end
    end

    // Capture the request payload and its position
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_pix.red   <= i_item.red_in;
            r_s1_pix.green <= i_item.green_in;
            r_s1_pix.blue  <= i_item.blue_in;
            r_s1_addr      <= r_load_idx;
            r_s1_col       <= r_col;
            r_s1_row       <= r_row;
        end
    end

    assign o_ctl  = r_s1_ctl;
    assign o_pix  = r_s1_pix;
    assign o_addr = r_s1_addr;
    assign o_col  = r_s1_col;
    assign o_row  = r_s1_row;

endmodule

`default_nettype wire

FILE: hw/rtl/irn_rotate.sv
// Coordinate rotation: products stage, then source range check and address stage.
`default_nettype none

module irn_rotate import irn_pkg::*; #(
    parameter int ADDR_W = 16,
    parameter int COL_W  = 8,
    parameter int ROW_W  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_ctl              i_ctl,
    input  t_pixel            i_pix,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [COL_W-1:0]  i_col,
    input  logic [ROW_W-1:0]  i_row,
    input  t_cfg              i_cfg,
    output t_ctl              o_ctl,
    output t_pixel            o_pix,
    output logic [ADDR_W-1:0] o_addr,
    output logic              o_in_frame
);

    // Stage A: products
    t_ctl                     r_a_ctl;
    t_pixel                   r_a_pix;
    logic [ADDR_W-1:0]        r_a_addr;
    logic signed [PART_W-1:0] r_pa, r_pb, r_pc, r_pd;

    // Stage B: address
    t_ctl                     r_b_ctl;
    t_pixel                   r_b_pix;
    logic [ADDR_W-1:0]        r_b_addr;
    logic                     r_b_in_frame;

    logic [WW-1:0]            half_w, half_h;
    logic signed [DX_W-1:0]   dx, dy;
    logic signed [TRIG_W-1:0] sin_s, cos_s;
    logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;
    logic signed [SRC_W-1:0]  sx, sy, hw_s, hh_s, w_s, h_s;
    logic                     in_frame;
    logic [FS_W-1:0]          src_idx;

    assign half_w = i_cfg.width >> 1;
    assign half_h = i_cfg.height >> 1;
    assign sin_s  = i_cfg.sin_v;
    assign cos_s  = i_cfg.cos_v;

    // Offset of the output position from the center
    assign dx = $signed({1'b0, DU_W'(i_col)}) - $signed({1'b0, DU_W'(half_w)});
    assign dy = $signed({1'b0, DU_W'(i_row)}) - $signed({1'b0, DU_W'(half_h)});

    assign p_xc = dx * cos_s;
    assign p_ys = dy * sin_s;
    assign p_xs = dx * sin_s;
    assign p_yc = dy * cos_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_adv) begin
            r_a_ctl <= i_ctl;
        end
    end

    // Drop the fraction bits; the top slice is the floor
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_pix  <= i_pix;
            r_a_addr <= i_addr;
            r_pa     <= p_xc[PROD_W-1:FRAC_BITS];
            r_pb     <= p_ys[PROD_W-1:FRAC_BITS];
            r_pc     <= p_xs[PROD_W-1:FRAC_BITS];
            r_pd     <= p_yc[PROD_W-1:FRAC_BITS];
        end
    end

    // Source coordinate and its bounds
    assign hw_s = $signed(SRC_W'(half_w));
    assign hh_s = $signed(SRC_W'(half_h));
    assign w_s  = $signed(SRC_W'(i_cfg.width));
    assign h_s  = $signed(SRC_W'(i_cfg.height));
    assign sx   = SRC_W'(r_pa) - SRC_W'(r_pb) + hw_s;
    assign sy   = SRC_W'(r_pc) + SRC_W'(r_pd) + hh_s;

    assign in_frame = !sx[SRC_W-1] && !sy[SRC_W-1] && (sx < w_s) && (sy < h_s);
    assign src_idx  = FS_W'(sy[WW-1:0]) * FS_W'(i_cfg.width) + FS_W'(sx[WW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_adv) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    // Loads keep their address; produces point at the source or entry zero
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_pix      <= r_a_pix;
            r_b_in_frame <= in_frame;
            if (r_a_ctl.load) begin
                r_b_addr <= r_a_addr;
            end else begin
                r_b_addr <= in_frame ? ADDR_W'(src_idx) : '0;
            end
        end
    end

    assign o_ctl      = r_b_ctl;
    assign o_pix      = r_b_pix;
    assign o_addr     = r_b_addr;
    assign o_in_frame = r_b_in_frame;

endmodule

`default_nettype wire

FILE: hw/rtl/irn_store.sv
// Frame store memory and the result register.
`default_nettype none

module irn_store import irn_pkg::*; #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_ctl              i_ctl,
    input  t_pixel            i_pix,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_in_frame,
    output logic              o_valid,
    output t_out_item         o_item
);

    t_pixel r_mem [DEPTH];
    t_pixel r_rdata;
    logic   r_out_valid;
    logic   r_in_frame;
    logic   r_last;

    // One access per slot: loads write, produces read
    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid) begin
            if (i_ctl.load) begin
                r_mem[i_addr] <= i_pix;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_ctl.valid && !i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_in_frame <= i_in_frame;
            r_last     <= i_ctl.last;
        end
    end

    // Black outside the image
    assign o_valid           = r_out_valid;
    assign o_item.red_out    = r_in_frame ? r_rdata.red   : '0;
    assign o_item.green_out  = r_in_frame ? r_rdata.green : '0;
    assign o_item.blue_out   = r_in_frame ? r_rdata.blue  : '0;
    assign o_item.last_pixel = r_last;

endmodule

`default_nettype wire

FILE: tb/sv/image_rotate_nearest_core_test.sv
// Self-checking testbench for the nearest-neighbor image rotation core.
module image_rotate_nearest_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import irn_pkg::*;

    localparam int MAX_W         = 256;
    localparam int MAX_H         = 256;
    localparam int STORE_DEPTH   = MAX_W * MAX_H;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PCT      = 10;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CALM_FROM     = 250;
    localparam int CALM_TO       = 400;

    // Raw register contents, sizes not yet clamped
    typedef struct packed {
        logic [WW-1:0]     width;
        logic [WW-1:0]     height;
        logic [TRIG_W-1:0] sin_v;
        logic [TRIG_W-1:0] cos_v;
    } t_rot_regs;

    // Load pointer and output raster position
    typedef struct packed {
        int load_idx;
        int col;
        int row;
    } t_scan_pos;

    typedef enum logic [1:0] {
        ACT_SEND,
        ACT_WRITE,
        ACT_DRAIN
    } t_act_kind;

    typedef struct packed {
        t_act_kind             kind;
        t_in_item              item;
        t_cfg_reg              reg_idx;
        logic [CFG_DATA_W-1:0] data;
    } t_stim_step;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    irn_stream_if #(.t_payload(t_in_item))  req_if ();
    irn_stream_if #(.t_payload(t_out_item)) rsp_if ();

    image_rotate_nearest_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Mirror of the block as seen at the ports
    t_pixel    frame_copy [STORE_DEPTH];
    t_rot_regs live_regs = '{RESET_SIZE, RESET_SIZE, RESET_SIN, RESET_COS};
    t_scan_pos live_pos  = '0;
    t_out_item due_pixels [$];

    // Planning copy, used only to keep produce requests off unwritten entries
    bit         loaded_map [STORE_DEPTH];
    t_rot_regs  plan_regs = '{RESET_SIZE, RESET_SIZE, RESET_SIN, RESET_COS};
    t_scan_pos  plan_pos  = '0;
    t_stim_step stim_queue [$];

    bit req_taken    = 1'b0;
    int req_count    = 0;
    int settle_left  = 0;
    int stall_cycles = 0;
    int fault_count  = 0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int clamp_dim(input logic [WW-1:0] v, input int lim);
        int r;
        r = int'(v);
        if (r < 1) begin
            r = 1;
        end else if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

    // Rotate an output coordinate about the center and locate its source pixel
    function automatic void find_source(input t_rot_regs r, input int col, input int row,
                                        output logic hit, output int addr);
        longint w, h, hw, hh, s, c, dx, dy, sx, sy;
        w  = clamp_dim(r.width, MAX_W);
        h  = clamp_dim(r.height, MAX_H);
        s  = longint'($signed(r.sin_v));
        c  = longint'($signed(r.cos_v));
        hw = w / 2;
        hh = h / 2;
        dx = col - hw;
        dy = row - hh;
        // arithmetic shift of a signed product floors toward minus infinity
        sx = ((dx * c) >>> FRAC_BITS) - ((dy * s) >>> FRAC_BITS) + hw;
        sy = ((dx * s) >>> FRAC_BITS) + ((dy * c) >>> FRAC_BITS) + hh;
        hit  = (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
        addr = hit ? int'(sy * w + sx) : 0;
    endfunction

    function automatic void step_load(input t_rot_regs r, inout t_scan_pos p);
        int total;
        total = clamp_dim(r.width, MAX_W) * clamp_dim(r.height, MAX_H);
        if (p.load_idx >= total - 1) begin
            p.load_idx = 0;
        end else begin
            p.load_idx = p.load_idx + 1;
        end
    endfunction

    // Advance the output raster; counters beyond a shrunken size wrap at once
    function automatic logic step_out(input t_rot_regs r, inout t_scan_pos p);
        int   w, h;
        logic last;
        w    = clamp_dim(r.width, MAX_W);
        h    = clamp_dim(r.height, MAX_H);
        last = (p.col >= w - 1) && (p.row >= h - 1);
        if (p.col >= w - 1) begin
            p.col = 0;
            if (p.row >= h - 1) begin
                p.row = 0;
            end else begin
                p.row = p.row + 1;
            end
        end else begin
            p.col = p.col + 1;
        end
        return last;
    endfunction

    // Queue a request; a produce that would read an unwritten entry becomes a load
    task automatic plan_request(input logic func, input logic [CH_W-1:0] r,
                                input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        logic       f;
        logic       hit;
        int         addr;
        t_stim_step st;
        f = func;
        if (f == FUNC_PRODUCE) begin
            find_source(plan_regs, plan_pos.col, plan_pos.row, hit, addr);
            if (hit && !loaded_map[addr]) begin
                f = FUNC_LOAD;
            end
        end
        if (f == FUNC_LOAD) begin
            loaded_map[plan_pos.load_idx] = 1'b1;
            step_load(plan_regs, plan_pos);
        end else begin
            void'(step_out(plan_regs, plan_pos));
        end
        st         = '0;
        st.kind    = ACT_SEND;
        st.item    = '{f, r, g, b};
        stim_queue = {stim_queue, st};
    endtask

    // Drain the block, then write every register
    task automatic plan_registers(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd,
                                  input logic [CFG_DATA_W-1:0] sd, input logic [CFG_DATA_W-1:0] cd);
        t_stim_step st;
        st      = '0;
        st.kind = ACT_DRAIN;
        stim_queue = {stim_queue, st};
        st.kind = ACT_WRITE;
        st.reg_idx = REG_WIDTH;
        st.data    = wd;
        stim_queue = {stim_queue, st};
        st.reg_idx = REG_HEIGHT;
        st.data    = hd;
        stim_queue = {stim_queue, st};
        st.reg_idx = REG_SIN;
        st.data    = sd;
        stim_queue = {stim_queue, st};
        st.reg_idx = REG_COS;
        st.data    = cd;
        stim_queue = {stim_queue, st};
        plan_regs = '{wd[WW-1:0], hd[WW-1:0], sd, cd};
    endtask

    // Driver: present requests, register writes and result back-pressure
    always @(negedge clk) begin : drive_proc
        logic                  nxt_valid;
        t_in_item              nxt_item;
        logic                  nxt_we;
        t_cfg_reg              nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        logic                  nxt_ready;
        bit                    calm;
        calm      = (req_count >= CALM_FROM) && (req_count < CALM_TO);
        nxt_valid = req_if.valid;
        nxt_item  = req_if.payload;
        nxt_we    = 1'b0;
        nxt_idx   = REG_WIDTH;
        nxt_data  = cfg_data;
        nxt_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (!rst_n) begin
            nxt_valid   = 1'b0;
            nxt_item    = '0;
            nxt_ready   = 1'b0;
            nxt_data    = '0;
            settle_left = 0;
        end else begin
            // drop a request once taken
            if (req_taken) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (settle_left > 0) begin
                    settle_left = settle_left - 1;
                end else if (stim_queue.size() != 0) begin
                    case (stim_queue[0].kind)
                        ACT_DRAIN: begin
                            // hold until every result is back, then let loads retire
                            if (due_pixels.size() == 0) begin
                                settle_left = SETTLE_CYCLES;
                                void'(stim_queue.pop_front());
                            end
                        end
                        ACT_WRITE: begin
                            nxt_we   = 1'b1;
                            nxt_idx  = stim_queue[0].reg_idx;
                            nxt_data = stim_queue[0].data;
                            void'(stim_queue.pop_front());
                        end
                        default: begin
                            if (calm || ($urandom_range(0, 99) >= IDLE_PCT)) begin
                                nxt_valid = 1'b1;
                                nxt_item  = stim_queue[0].item;
                                void'(stim_queue.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
        req_if.valid   <= nxt_valid;
        req_if.payload <= nxt_item;
        rsp_if.ready   <= nxt_ready;
        cfg_we         <= nxt_we;
        cfg_idx        <= nxt_idx;
        cfg_data       <= nxt_data;
    end

    // Monitor: check results, track register writes, predict each accepted request
    always @(posedge clk) begin : watch_proc
        t_out_item head;
        t_out_item want_px;
        t_pixel    px;
        logic      hit;
        int        addr;
        bit        busy;
        req_taken = 1'b0;
        if (rst_n) begin
            busy = 1'b0;
            if (rsp_if.valid && rsp_if.ready) begin
                busy = 1'b1;
                if (due_pixels.size() == 0) begin
                    $error("result with no request pending");
                    fault_count++;
                end else begin
                    head = due_pixels.pop_front();
                    if (rsp_if.payload.red_out !== head.red_out) begin
                        $error("red_out: expected %0d, actual %0d",
                               head.red_out, rsp_if.payload.red_out);
                        fault_count++;
                    end
                    if (rsp_if.payload.green_out !== head.green_out) begin
                        $error("green_out: expected %0d, actual %0d",
                               head.green_out, rsp_if.payload.green_out);
                        fault_count++;
                    end
                    if (rsp_if.payload.blue_out !== head.blue_out) begin
                        $error("blue_out: expected %0d, actual %0d",
                               head.blue_out, rsp_if.payload.blue_out);
                        fault_count++;
                    end
                    if (rsp_if.payload.last_pixel !== head.last_pixel) begin
                        $error("last_pixel: expected %0d, actual %0d",
                               head.last_pixel, rsp_if.payload.last_pixel);
                        fault_count++;
                    end
                end
            end

            if (cfg_we) begin
                busy = 1'b1;
                case (cfg_idx)
                    REG_WIDTH:  live_regs.width  = cfg_data[WW-1:0];
                    REG_HEIGHT: live_regs.height = cfg_data[WW-1:0];
                    REG_SIN:    live_regs.sin_v  = cfg_data[TRIG_W-1:0];
                    REG_COS:    live_regs.cos_v  = cfg_data[TRIG_W-1:0];
                    default: ;
                endcase
            end

            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                busy = 1'b1;
                req_count++;
                if (req_if.payload.func == FUNC_LOAD) begin
                    frame_copy[live_pos.load_idx] = '{req_if.payload.red_in,
                                                      req_if.payload.green_in,
                                                      req_if.payload.blue_in};
                    step_load(live_regs, live_pos);
                end else begin
                    find_source(live_regs, live_pos.col, live_pos.row, hit, addr);
                    px = hit ? frame_copy[addr] : '0;
                    want_px.red_out    = px.red;
                    want_px.green_out  = px.green;
                    want_px.blue_out   = px.blue;
                    want_px.last_pixel = step_out(live_regs, live_pos);
                    due_pixels = {due_pixels, want_px};
                end
            end

            // give up when nothing moves for too long
            stall_cycles = busy ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stim_proc
        int                    rand_items;
        int                    phase_no;
        int                    n;
        int                    total;
        int                    sel;
        logic [CFG_DATA_W-1:0] wd, hd, sd, cd;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;

        // Reset sizes and identity angle: channel extremes, then read them back
        plan_request(FUNC_LOAD, 8'h00, 8'h00, 8'h00);
        plan_request(FUNC_LOAD, 8'hFF, 8'hFF, 8'hFF);
        plan_request(FUNC_LOAD, 8'hFF, 8'h00, 8'hAA);
        plan_request(FUNC_LOAD, 8'h00, 8'hFF, 8'h55);
        plan_request(FUNC_LOAD, 8'h5A, 8'hA5, 8'h0F);
        plan_request(FUNC_LOAD, 8'hC3, 8'h3C, 8'hF0);
        repeat (4) plan_request(FUNC_PRODUCE, 8'hFF, 8'hFF, 8'hFF);

        // Shrink to one pixel with counters left beyond it: both wraps, last on every pixel
        plan_registers(16'h0001, 16'h0001, 16'h0000, 16'h4000);
        repeat (2) plan_request(FUNC_PRODUCE, 8'h00, 8'h00, 8'h00);
        plan_request(FUNC_LOAD, 8'h12, 8'h34, 8'h56);
        plan_request(FUNC_LOAD, 8'hED, 8'hCB, 8'hA9);
        plan_request(FUNC_PRODUCE, 8'hFF, 8'hFF, 8'hFF);

        // Zero width, oversize height, extreme trig patterns
        plan_registers(16'hFE00, 16'hFFFF, 16'h8000, 16'h7FFF);
        repeat (3) plan_request(FUNC_PRODUCE, 8'hAA, 8'h55, 8'hAA);
        plan_request(FUNC_LOAD, 8'h80, 8'h01, 8'h7F);
        plan_request(FUNC_LOAD, 8'h01, 8'h80, 8'hFE);

        // Random phases, a few fixed corners first
        rand_items = 0;
        phase_no   = 0;
        while (rand_items < RANDOM_ITEMS) begin
            case (phase_no)
                0: begin
                    wd = 16'd2;   hd = 16'd2;   sd = 16'h4000;   cd = 16'h0000;
                end
                1: begin
                    wd = 16'd511; hd = 16'd3;   sd = -16'sd16384; cd = 16'h0000;
                end
                2: begin
                    wd = 16'd7;   hd = 16'd5;   sd = 16'h8000;   cd = 16'h7FFF;
                end
                3: begin
                    wd = 16'd256; hd = 16'd256; sd = 16'd11585;  cd = 16'd11585;
                end
                4: begin
                    wd = 16'd3;   hd = 16'd0;   sd = 16'h0000;   cd = -16'sd16384;
                end
                default: begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0) begin
                        wd = 16'($urandom_range(129, 511));
                        hd = 16'($urandom_range(129, 511));
                    end else if (sel == 1) begin
                        wd = 16'($urandom_range(13, 64));
                        hd = 16'($urandom_range(13, 64));
                    end else begin
                        wd = 16'($urandom_range(0, 12));
                        hd = 16'($urandom_range(0, 12));
                    end
                    // junk above the size field must be dropped
                    wd[15:WW] = 7'($urandom);
                    hd[15:WW] = 7'($urandom);
                    sel = $urandom_range(0, 3);
                    if (sel == 0) begin
                        sd = 16'($urandom);
                        cd = 16'($urandom);
                    end else if (sel == 1) begin
                        case ($urandom_range(0, 7))
                            0: begin sd = 16'sd0;      cd = 16'sd16384;  end
                            1: begin sd = 16'sd11585;  cd = 16'sd11585;  end
                            2: begin sd = 16'sd16384;  cd = 16'sd0;      end
                            3: begin sd = 16'sd11585;  cd = -16'sd11585; end
                            4: begin sd = 16'sd0;      cd = -16'sd16384; end
                            5: begin sd = -16'sd11585; cd = -16'sd11585; end
                            6: begin sd = -16'sd16384; cd = 16'sd0;      end
                            default: begin sd = -16'sd11585; cd = 16'sd11585; end
                        endcase
                    end else begin
                        sd = 16'($urandom_range(0, 32768) - 16384);
                        cd = 16'($urandom_range(0, 32768) - 16384);
                    end
                end
            endcase
            plan_registers(wd, hd, sd, cd);

            // small frames get over twice their pixel count in requests, so the raster can wrap
            total = clamp_dim(wd[WW-1:0], MAX_W) * clamp_dim(hd[WW-1:0], MAX_H);
            n = (total <= 64) ? 2 * total + $urandom_range(8, 24) : $urandom_range(30, 60);
            repeat (n) begin
                plan_request(($urandom_range(0, 99) < 60) ? FUNC_PRODUCE : FUNC_LOAD,
                             8'($urandom), 8'($urandom), 8'($urandom));
            end
            rand_items += n;
            phase_no++;
        end

        // Release reset and let the driver run
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_queue.size() != 0 || req_if.valid || due_pixels.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
